FILE: design/owm_pkg.sv
// ----------------------------------------------------------------------------
// owm_pkg: shared types and constants of the 1-Wire bus master
// Field widths, command, drive and status codes, phase encoding and the
// reset values of the slot timing registers.
// ----------------------------------------------------------------------------
`default_nettype none

package owm_pkg;

  localparam int MAX_BITS_DEF   = 64;
  localparam int TIME_WIDTH_DEF = 10;

  localparam int REQ_W    = 2;
  localparam int COUNT_W  = 7;
  localparam int DATA_W   = 64;
  localparam int DRIVE_W  = 2;
  localparam int STATUS_W = 2;

  localparam int NUM_REGS  = 8;
  localparam int REG_IDX_W = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_RESET_LOW     = 3'd0,
    REG_PRESENCE_WAIT = 3'd1,
    REG_PRESENCE_HOLD = 3'd2,
    REG_WR_ONE_LOW    = 3'd3,
    REG_WR_ONE_REL    = 3'd4,
    REG_WR_ZERO_LOW   = 3'd5,
    REG_RD_SAMPLE     = 3'd6,
    REG_RD_REST       = 3'd7
  } reg_idx_t;

  localparam int REG_DEFAULT [NUM_REGS] = '{500, 60, 240, 5, 50, 60, 5, 45};

  typedef enum logic [REQ_W-1:0] {
    REQ_NONE  = 2'd0,
    REQ_RESET = 2'd1,
    REQ_WRITE = 2'd2,
    REQ_READ  = 2'd3
  } req_t;

  typedef enum logic [DRIVE_W-1:0] {
    DRV_RELEASE = 2'd0,
    DRV_LOW     = 2'd1,
    DRV_HIGH    = 2'd2
  } drive_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 2'd0,
    ST_NO_PRESENCE  = 2'd1,
    ST_NOT_RELEASED = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_RST_LOW  = 4'd1,
    PH_RST_WAIT = 4'd2,
    PH_RST_HOLD = 4'd3,
    PH_WR_REC   = 4'd4,
    PH_WR_LOW   = 4'd5,
    PH_WR_REL   = 4'd6,
    PH_RD_REC   = 4'd7,
    PH_RD_LOW   = 4'd8,
    PH_RD_WAIT  = 4'd9,
    PH_RD_REST  = 4'd10
  } phase_t;

endpackage

`default_nettype wire

FILE: design/owm_in_if.sv
// ----------------------------------------------------------------------------
// owm_in_if: tick channel of the 1-Wire bus master
// Valid/ready channel carrying the command fields and the sampled line level.
// ----------------------------------------------------------------------------
`default_nettype none

interface owm_in_if import owm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [REQ_W-1:0]   req_type;
  logic [COUNT_W-1:0] bit_count;
  logic [DATA_W-1:0]  write_data;
  logic               line_in;

  modport source (output valid, output req_type, output bit_count,
                  output write_data, output line_in, input ready);
  modport sink   (input valid, input req_type, input bit_count,
                  input write_data, input line_in, output ready);
endinterface

`default_nettype wire

FILE: design/owm_out_if.sv
// ----------------------------------------------------------------------------
// owm_out_if: result channel of the 1-Wire bus master
// Valid/ready channel carrying line drive, busy, done, status and read word.
// ----------------------------------------------------------------------------
`default_nettype none

interface owm_out_if import owm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [DRIVE_W-1:0]  line_drive;
  logic                busy_res;
  logic                done_res;
  logic [STATUS_W-1:0] status;
  logic [DATA_W-1:0]   read_data;

  modport source (output valid, output line_drive, output busy_res,
                  output done_res, output status, output read_data, input ready);
  modport sink   (input valid, input line_drive, input busy_res,
                  input done_res, input status, input read_data, output ready);
endinterface

`default_nettype wire

FILE: design/owm_regs.sv
// ----------------------------------------------------------------------------
// owm_regs: slot timing register bank
// Eight timing registers written through the plain configuration port.
// ----------------------------------------------------------------------------
`default_nettype none

module owm_regs import owm_pkg::*; #(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [REG_IDX_W-1:0]  cfg_index,
  input  wire logic [TIME_WIDTH-1:0] cfg_data,
  output logic      [TIME_WIDTH-1:0] timing [NUM_REGS]
);

  logic [TIME_WIDTH-1:0] timing_r [NUM_REGS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        // defaults keep only the bits that fit the timer width
        timing_r[i] <= TIME_WIDTH'(REG_DEFAULT[i]);
      end
    end else if (cfg_we) begin
      timing_r[cfg_index] <= cfg_data;
    end
  end

  assign timing = timing_r;

endmodule

`default_nettype wire

FILE: design/owm_in_stage.sv
// ----------------------------------------------------------------------------
// owm_in_stage: input register
// Registers one tick beat; takes the next beat while the held one moves on.
// ----------------------------------------------------------------------------
`default_nettype none

module owm_in_stage import owm_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  owm_in_if.sink    up,
  owm_in_if.source  dn
);

  logic               valid_r;
  logic [REQ_W-1:0]   req_r;
  logic [COUNT_W-1:0] count_r;
  logic [DATA_W-1:0]  wdata_r;
  logic               line_r;
  logic               take;

  assign up.ready = !valid_r || dn.ready;
  assign take     = up.valid && up.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= 1'b1;
    end else if (dn.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      req_r   <= up.req_type;
      count_r <= up.bit_count;
      wdata_r <= up.write_data;
      line_r  <= up.line_in;
    end
  end

  assign dn.valid      = valid_r;
  assign dn.req_type   = req_r;
  assign dn.bit_count  = count_r;
  assign dn.write_data = wdata_r;
  assign dn.line_in    = line_r;

endmodule

`default_nettype wire

FILE: design/owm_core.sv
// ----------------------------------------------------------------------------
// owm_core: bus sequencer and result register
// Advances the reset, write and read slot sequencer by one tick per beat and
// registers that tick's drive, busy, done, status and read word.
// ----------------------------------------------------------------------------
`default_nettype none

module owm_core import owm_pkg::*; #(
  parameter int MAX_BITS   = MAX_BITS_DEF,
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic [TIME_WIDTH-1:0] timing [NUM_REGS],
  owm_in_if.sink                     up,
  owm_out_if.source                  dn
);

  localparam int BW = $clog2(MAX_BITS + 1);
  localparam int SW = $clog2(MAX_BITS);

  phase_t                phase_r,  phase_nxt;
  logic [TIME_WIDTH-1:0] tick_r,   tick_nxt;
  logic [BW-1:0]         left_r,   left_nxt;
  logic [BW-1:0]         total_r,  total_nxt;
  logic [MAX_BITS-1:0]   shift_r,  shift_nxt;
  req_t                  kind_r,   kind_nxt;
  status_t               status_r, status_nxt;

  logic                  out_valid_r;
  drive_t                drive_r,  drive_nxt;
  logic                  busy_r,   busy_nxt;
  logic                  done_r,   done_nxt;
  logic [DATA_W-1:0]     rdata_r,  rdata_nxt;

  logic                  fire;

  assign up.ready = !out_valid_r || dn.ready;
  assign fire     = up.valid && up.ready;

  always_comb begin
    req_t                  req;
    logic [COUNT_W-1:0]    cnt;
    logic [TIME_WIDTH-1:0] dur;
    logic [TIME_WIDTH:0]   tick_inc;
    logic                  over;
    logic [SW-1:0]         align;

    req        = req_t'(up.req_type);
    cnt        = up.bit_count;
    phase_nxt  = phase_r;
    tick_nxt   = tick_r;
    left_nxt   = left_r;
    total_nxt  = total_r;
    shift_nxt  = shift_r;
    kind_nxt   = kind_r;
    status_nxt = status_r;
    drive_nxt  = DRV_RELEASE;
    done_nxt   = 1'b0;

    // take a command on an idle tick; this tick already runs the operation
    if (phase_r == PH_IDLE && req != REQ_NONE) begin
      if (cnt == '0) begin
        cnt = COUNT_W'(1);
      end else if (cnt > COUNT_W'(MAX_BITS)) begin
        cnt = COUNT_W'(MAX_BITS);
      end
      kind_nxt   = req;
      status_nxt = ST_OK;
      tick_nxt   = '0;
      left_nxt   = BW'(cnt);
      total_nxt  = BW'(cnt);
      if (req == REQ_RESET) begin
        phase_nxt = PH_RST_LOW;
        shift_nxt = '0;
      end else if (req == REQ_WRITE) begin
        phase_nxt = PH_WR_REC;
        shift_nxt = up.write_data[MAX_BITS-1:0];
      end else begin
        phase_nxt = PH_RD_REC;
        shift_nxt = '0;
      end
    end

    busy_nxt = (phase_nxt != PH_IDLE);

    // duration of the current phase
    case (phase_nxt)
      PH_RST_LOW:  dur = timing[REG_RESET_LOW];
      PH_RST_WAIT: dur = timing[REG_PRESENCE_WAIT];
      PH_RST_HOLD: dur = timing[REG_PRESENCE_HOLD];
      PH_WR_LOW:   dur = shift_nxt[0] ? timing[REG_WR_ONE_LOW] : timing[REG_WR_ZERO_LOW];
      PH_WR_REL:   dur = shift_nxt[0] ? timing[REG_WR_ONE_REL] : TIME_WIDTH'(1);
      PH_RD_WAIT:  dur = timing[REG_RD_SAMPLE];
      PH_RD_REST:  dur = timing[REG_RD_REST];
      default:     dur = TIME_WIDTH'(1);
    endcase

    tick_inc = {1'b0, tick_nxt} + (TIME_WIDTH+1)'(1);
    over     = (tick_inc >= {1'b0, dur});
    align    = SW'(BW'(MAX_BITS) - total_nxt);

    unique case (phase_nxt)
      PH_RST_LOW: begin
        drive_nxt = DRV_LOW;
        if (over) phase_nxt = PH_RST_WAIT;
      end
      PH_RST_WAIT: begin
        if (over) begin
          if (up.line_in) begin
            status_nxt = ST_NO_PRESENCE;
            done_nxt   = 1'b1;
            phase_nxt  = PH_IDLE;
          end else begin
            phase_nxt = PH_RST_HOLD;
          end
        end
      end
      PH_RST_HOLD: begin
        if (over) begin
          status_nxt = up.line_in ? ST_OK : ST_NOT_RELEASED;
          done_nxt   = 1'b1;
          phase_nxt  = PH_IDLE;
        end
      end
      PH_WR_REC: begin
        if (over) phase_nxt = PH_WR_LOW;
      end
      PH_WR_LOW: begin
        drive_nxt = DRV_LOW;
        if (over) phase_nxt = PH_WR_REL;
      end
      PH_WR_REL: begin
        if (over) begin
          shift_nxt = shift_nxt >> 1;
          left_nxt  = left_nxt - BW'(1);
          if (left_nxt == '0) begin
            done_nxt  = 1'b1;
            phase_nxt = PH_IDLE;
          end else begin
            phase_nxt = PH_WR_REC;
          end
        end
      end
      PH_RD_REC: begin
        if (over) phase_nxt = PH_RD_LOW;
      end
      PH_RD_LOW: begin
        drive_nxt = DRV_LOW;
        if (over) phase_nxt = PH_RD_WAIT;
      end
      PH_RD_WAIT: begin
        if (over) begin
          // sample enters at the top; realigned at the end of the read
          shift_nxt = {up.line_in, shift_nxt[MAX_BITS-1:1]};
          phase_nxt = PH_RD_REST;
        end
      end
      PH_RD_REST: begin
        if (over) begin
          left_nxt = left_nxt - BW'(1);
          if (left_nxt == '0) begin
            shift_nxt = shift_nxt >> align;
            done_nxt  = 1'b1;
            phase_nxt = PH_IDLE;
          end else begin
            phase_nxt = PH_RD_REC;
          end
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        over      = 1'b1;
      end
    endcase

    tick_nxt  = over ? '0 : tick_inc[TIME_WIDTH-1:0];
    rdata_nxt = (phase_nxt == PH_IDLE && kind_nxt == REQ_READ) ? DATA_W'(shift_nxt) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      tick_r      <= '0;
      left_r      <= '0;
      total_r     <= '0;
      shift_r     <= '0;
      kind_r      <= REQ_NONE;
      status_r    <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        phase_r     <= phase_nxt;
        tick_r      <= tick_nxt;
        left_r      <= left_nxt;
        total_r     <= total_nxt;
        shift_r     <= shift_nxt;
        kind_r      <= kind_nxt;
        status_r    <= status_nxt;
        out_valid_r <= 1'b1;
      end else if (dn.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // hold the result beat until it is taken
  always_ff @(posedge clk) begin
    if (fire) begin
      drive_r <= drive_nxt;
      busy_r  <= busy_nxt;
      done_r  <= done_nxt;
      rdata_r <= rdata_nxt;
    end
  end

  assign dn.valid      = out_valid_r;
  assign dn.line_drive = drive_r;
  assign dn.busy_res   = busy_r;
  assign dn.done_res   = done_r;
  assign dn.status     = status_r;
  assign dn.read_data  = rdata_r;

endmodule

`default_nettype wire

FILE: design/onewire_bus_master.sv
// ----------------------------------------------------------------------------
// onewire_bus_master: 1-Wire bus master, one beat per microsecond tick
// Reset with presence check, write and read of up to MAX_BITS bits, with
// slot timings from eight configuration registers.
// ----------------------------------------------------------------------------
//  port       dir  kind          carries
//  in_ch      in   valid/ready   req_type, bit_count, write_data, line_in
//  out_ch     out  valid/ready   line_drive, busy_res, done_res, status, read_data
//  cfg_*      in   write only    cfg_we, cfg_index, cfg_data
//
//  Every tick beat gives exactly one result beat; it passes the input register,
//  then the sequencer and result register.
//  A beat can be taken every cycle while result beats are taken; the sequencer advances one step per beat.
//  A result beat that is not taken holds the result register; once the input
//  register is also full, in_ch.ready drops.
//  Synchronous reset leaves the sequencer idle and loads default timings.
// ----------------------------------------------------------------------------
`default_nettype none

module onewire_bus_master import owm_pkg::*; #(
  parameter int MAX_BITS   = MAX_BITS_DEF,
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  owm_in_if.sink                     in_ch,
  owm_out_if.source                  out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [REG_IDX_W-1:0]  cfg_index,
  input  wire logic [TIME_WIDTH-1:0] cfg_data
);

  logic [TIME_WIDTH-1:0] timing [NUM_REGS];

  owm_in_if link_ch ();

  owm_regs #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .timing    (timing)
  );

  owm_in_stage u_in_stage (
    .clk   (clk),
    .rst_n (rst_n),
    .up    (in_ch),
    .dn    (link_ch)
  );

  owm_core #(
    .MAX_BITS   (MAX_BITS),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .timing (timing),
    .up     (link_ch),
    .dn     (out_ch)
  );

endmodule

`default_nettype wire
